/* rtl/core/mstd_pkg.sv */
// mstd_pkg: shared types and constants of the dense prim spanning tree core
// no dependencies; imported by every module of the core
`default_nettype none

package mstd_pkg;

    // fixed field widths of the external interface
    localparam int VERTEX_W    = 5;
    localparam int WEIGHT_IN_W = 20;
    localparam int COST_W      = 25;
    localparam int CFG_W       = 6;

    // parameter defaults
    localparam int MAX_VERTICES_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 20;

    // at most MAX_RESULTS - 1 tree edge beats per run, then the summary beat
    localparam int MAX_RESULTS = 32;

    localparam logic [CFG_W-1:0]  VERTEX_COUNT_RST = 6'd32;
    localparam logic [COST_W-1:0] COST_MAX         = '1;

    // input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // result kinds
    localparam logic KIND_EDGE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_NEXT,
        ST_EMIT,
        ST_SUMMARY
    } mstd_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load_write;
        logic clear_step;
        logic run_init;
        logic scan_issue;
        logic next_pass;
        logic emit_start;
        logic emit_step;
        logic send_summary;
    } mstd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic n_zero;
        logic scan_last;
        logic found;
        logic emit_done;
        logic emit_stall;
        logic out_free;
    } mstd_sts_t;

endpackage

`default_nettype wire

/* rtl/core/mstd_ctrl.sv */
// mstd_ctrl: sequencing state machine of the dense prim spanning tree core
// depends on mstd_pkg for the state, command and status types
`default_nettype none

module mstd_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    input  wire                   command,
    output logic                  in_ready,
    input  mstd_pkg::mstd_sts_t   sts,
    output mstd_pkg::mstd_cmd_t   cmd
);
    import mstd_pkg::*;

    mstd_state_t state_reg;
    mstd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (command == CMD_RUN) ? ST_INIT : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_INIT:
            begin
                cmd.run_init = 1'b1;
                if (sts.n_zero)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (sts.found)
                begin
                    cmd.next_pass = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.emit_done)
                begin
                    state_next = ST_SUMMARY;
                end
                else if (!sts.emit_stall)
                begin
                    cmd.emit_step = 1'b1;
                end
            end
            ST_SUMMARY:
            begin
                if (sts.out_free)
                begin
                    cmd.send_summary = 1'b1;
                    state_next       = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/mstd_dp.sv */
// mstd_dp: adjacency ram, per-vertex prim work store, cost sum and result register
// depends on mstd_pkg; driven by mstd_ctrl through command and status structs
`default_nettype none

module mstd_dp #(
    parameter int MAX_VERTICES = mstd_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = mstd_pkg::WEIGHT_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_wr_en,
    input  wire  [mstd_pkg::CFG_W-1:0]           cfg_wr_data,
    input  wire  [mstd_pkg::VERTEX_W-1:0]        from_vertex,
    input  wire  [mstd_pkg::VERTEX_W-1:0]        to_vertex,
    input  wire  [mstd_pkg::WEIGHT_IN_W-1:0]     weight,
    input  wire                                  out_ready,
    input  mstd_pkg::mstd_cmd_t                  cmd,
    output mstd_pkg::mstd_sts_t                  sts,
    output logic                                 out_valid,
    output logic                                 kind,
    output logic [mstd_pkg::VERTEX_W-1:0]        parent_vertex,
    output logic [mstd_pkg::VERTEX_W-1:0]        child_vertex,
    output logic [mstd_pkg::WEIGHT_IN_W-1:0]     edge_weight,
    output logic [mstd_pkg::COST_W-1:0]          total_cost,
    output logic                                 last
);
    import mstd_pkg::*;

    localparam int VB     = $clog2(MAX_VERTICES);
    localparam int AW     = 2 * VB;
    localparam int DEPTH  = 1 << AW;
    localparam int KW     = WEIGHT_BITS + 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int RES_W  = $clog2(MAX_RESULTS);
    localparam int SUM_W  = ((WEIGHT_BITS > COST_W) ? WEIGHT_BITS : COST_W) + 1;
    localparam logic [KW-1:0] NO_EDGE = KW'(1) << WEIGHT_BITS;

    // upper triangle address, the store is symmetric
    function automatic logic [AW-1:0] pair_addr(input logic [VB-1:0] a,
                                                input logic [VB-1:0] b);
        logic [AW-1:0] r;
        if (a < b)
        begin
            r = {a, b};
        end
        else
        begin
            r = {b, a};
        end
        return r;
    endfunction

    // configuration
    logic [CFG_W-1:0] vc_reg;
    logic [CNT_W-1:0] n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VERTEX_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            vc_reg <= cfg_wr_data;
        end
    end

    assign n = (int'(vc_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vc_reg);

    // adjacency ram
    logic [KW-1:0] adj_mem [DEPTH];
    logic [KW-1:0] rd_data_reg;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_waddr;
    logic [KW-1:0] mem_wdata;
    logic          mem_we;

    // load capture
    logic [AW-1:0]          ld_addr_reg;
    logic [WEIGHT_BITS-1:0] ld_w_reg;
    logic                   ld_ok_reg;

    // clearing sweep
    logic [AW-1:0] clr_reg;

    // prim work store and scan state
    logic [KW-1:0]    key_arr    [MAX_VERTICES];
    logic [VB-1:0]    parent_arr [MAX_VERTICES];
    logic             queued_arr [MAX_VERTICES];
    logic [VB-1:0]    u_reg;
    logic [VB-1:0]    scan_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             stage_valid_reg;
    logic [KW-1:0]    min_reg;
    logic [VB-1:0]    cand_reg;
    logic [COST_W-1:0] cost_reg;
    logic [RES_W-1:0] res_cnt_reg;

    logic [VB-1:0]    cur_v;
    logic [KW-1:0]    cur_key;
    logic             cur_q;
    logic             relax;
    logic [KW-1:0]    new_key;
    logic             better;
    logic             emit_has;
    logic             emit_out;
    logic [SUM_W-1:0] cost_sum;
    logic [COST_W-1:0] cost_sat;
    logic             load_out;
    logic             out_free;

    assign mem_raddr = cmd.scan_issue ? pair_addr(u_reg, scan_reg)
                                      : pair_addr(VB'(from_vertex), VB'(to_vertex));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ld_addr_reg;
        mem_wdata = {1'b0, ld_w_reg};
        if (cmd.clear_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = NO_EDGE;
        end
        else if (cmd.load_write && ld_ok_reg && ({1'b0, ld_w_reg} < rd_data_reg))
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            adj_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= adj_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ld_addr_reg <= pair_addr(VB'(from_vertex), VB'(to_vertex));
            ld_w_reg    <= WEIGHT_BITS'(weight);
            ld_ok_reg   <= (32'(from_vertex) < 32'(n)) && (32'(to_vertex) < 32'(n))
                           && (from_vertex != to_vertex);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    // relaxation stage, one vertex per cycle behind the ram read
    assign cur_v   = idx_reg[VB-1:0];
    assign cur_key = key_arr[cur_v];
    assign cur_q   = queued_arr[cur_v];
    assign relax   = stage_valid_reg && cur_q && (rd_data_reg != NO_EDGE)
                     && (rd_data_reg < cur_key);
    assign new_key = relax ? rd_data_reg : cur_key;
    assign better  = stage_valid_reg && cur_q && (new_key < min_reg);

    // emission
    assign emit_has = (cur_key != NO_EDGE);
    assign emit_out = emit_has && (int'(res_cnt_reg) < (MAX_RESULTS - 1));
    assign cost_sum = SUM_W'(cost_reg) + SUM_W'(cur_key);
    assign cost_sat = (cost_sum > SUM_W'(COST_MAX)) ? COST_MAX : COST_W'(cost_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.run_init)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                key_arr[i]    <= (i == 0) ? '0 : NO_EDGE;
                parent_arr[i] <= '0;
                queued_arr[i] <= (i != 0);
            end
        end
        else
        begin
            if (relax)
            begin
                key_arr[cur_v]    <= rd_data_reg;
                parent_arr[cur_v] <= u_reg;
            end
            if (cmd.next_pass)
            begin
                queued_arr[cand_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= cmd.scan_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.run_init)
        begin
            u_reg       <= '0;
            scan_reg    <= '0;
            min_reg     <= NO_EDGE;
            cost_reg    <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.scan_issue)
            begin
                scan_reg <= scan_reg + VB'(1);
            end
            if (cmd.next_pass)
            begin
                u_reg    <= cand_reg;
                scan_reg <= '0;
                min_reg  <= NO_EDGE;
            end
            else if (better)
            begin
                min_reg  <= new_key;
                cand_reg <= cur_v;
            end
            if (cmd.emit_step && emit_has)
            begin
                cost_reg <= cost_sat;
                if (emit_out)
                begin
                    res_cnt_reg <= res_cnt_reg + RES_W'(1);
                end
            end
        end
        if (cmd.scan_issue)
        begin
            idx_reg <= CNT_W'(scan_reg);
        end
        else if (cmd.emit_start)
        begin
            idx_reg <= CNT_W'(1);
        end
        else if (cmd.emit_step)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    // result register
    assign out_free = !out_valid || out_ready;
    assign load_out = (cmd.emit_step && emit_out) || cmd.send_summary;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.send_summary)
        begin
            kind          <= KIND_SUMMARY;
            parent_vertex <= '0;
            child_vertex  <= '0;
            edge_weight   <= '0;
            total_cost    <= cost_reg;
            last          <= 1'b1;
        end
        else if (load_out)
        begin
            kind          <= KIND_EDGE;
            parent_vertex <= VERTEX_W'(parent_arr[cur_v]);
            child_vertex  <= VERTEX_W'(idx_reg);
            edge_weight   <= WEIGHT_IN_W'(cur_key);
            total_cost    <= '0;
            last          <= 1'b0;
        end
    end

    // status
    assign sts.clear_last = &clr_reg;
    assign sts.n_zero     = (n == '0);
    assign sts.scan_last  = (CNT_W'(scan_reg) == (n - CNT_W'(1)));
    assign sts.found      = (min_reg != NO_EDGE);
    assign sts.emit_done  = (idx_reg >= n);
    assign sts.emit_stall = emit_out && !out_free;
    assign sts.out_free   = out_free;

endmodule

`default_nettype wire

/* rtl/core/min_spanning_tree_dense_core.sv */
// min_spanning_tree_dense_core: top level of the dense prim spanning tree engine
// depends on mstd_pkg, mstd_ctrl and mstd_dp
`default_nettype none

// Edges are loaded one per input beat (command 0) into an adjacency ram that
// keeps the upper triangle of a symmetric weight matrix; a repeated edge keeps
// its smallest weight, and self-loops or edges with an endpoint at or beyond the
// active vertex count are dropped. The ram is read at the accept edge and the
// compare-and-write follows in the next cycle. A run (command 1) starts prim
// from vertex 0: an init state, then for each vertex taken into the tree one
// pass that streams that vertex's matrix row through the ram port, relaxing
// keys and tracking the next minimum in the same pass. Results then leave one
// per cycle at best (fewer under back-pressure): the emission walks children 1
// to n - 1, closes, then the summary beat follows. Tree edge beats come in
// child index order, at most 31 of them, then a summary beat with the saturated
// total cost and last set. After the summary is loaded the ram is swept back
// to the no-edge value, all 2^(2*ceil(log2 MAX_VERTICES)) entries (1024 by
// default); the same sweep runs after reset. in_ready is low during runs and
// sweeps, while the vertex count register may be written at any time the block
// is idle.
module min_spanning_tree_dense_core #(
    parameter int MAX_VERTICES = mstd_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = mstd_pkg::WEIGHT_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // vertex count register
    input  wire                               cfg_wr_en,
    input  wire  [mstd_pkg::CFG_W-1:0]        cfg_wr_data,
    // command beats
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire                               command,
    input  wire  [mstd_pkg::VERTEX_W-1:0]     from_vertex,
    input  wire  [mstd_pkg::VERTEX_W-1:0]     to_vertex,
    input  wire  [mstd_pkg::WEIGHT_IN_W-1:0]  weight,
    // result beats
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic                              kind,
    output logic [mstd_pkg::VERTEX_W-1:0]     parent_vertex,
    output logic [mstd_pkg::VERTEX_W-1:0]     child_vertex,
    output logic [mstd_pkg::WEIGHT_IN_W-1:0]  edge_weight,
    output logic [mstd_pkg::COST_W-1:0]       total_cost,
    output logic                              last
);
    import mstd_pkg::*;

    mstd_cmd_t cmd;
    mstd_sts_t sts;

    // sequencer: load, run passes, emission, sweep
    mstd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // adjacency ram, key store, cost and output register
    mstd_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .from_vertex   (from_vertex),
        .to_vertex     (to_vertex),
        .weight        (weight),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .kind          (kind),
        .parent_vertex (parent_vertex),
        .child_vertex  (child_vertex),
        .edge_weight   (edge_weight),
        .total_cost    (total_cost),
        .last          (last)
    );

endmodule

`default_nettype wire

/* rtl/core/mstd_checker.sv */
// mstd_checker: port-level checks of the dense prim spanning tree core
// depends on mstd_pkg; bound to min_spanning_tree_dense_core below
`default_nettype none

module mstd_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               in_valid,
    input wire                               in_ready,
    input wire                               out_valid,
    input wire                               out_ready,
    input wire                               kind,
    input wire  [mstd_pkg::VERTEX_W-1:0]     parent_vertex,
    input wire  [mstd_pkg::VERTEX_W-1:0]     child_vertex,
    input wire  [mstd_pkg::WEIGHT_IN_W-1:0]  edge_weight,
    input wire  [mstd_pkg::COST_W-1:0]       total_cost,
    input wire                               last
);
    import mstd_pkg::*;

    // a held result beat keeps its payload (parent_vertex is not checked)
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(kind) && $stable(child_vertex)
             && $stable(edge_weight) && $stable(total_cost) && $stable(last)))
        else $error("result beat changed while stalled");

    // only the summary beat closes a run
    a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_SUMMARY) == last))
        else $error("kind and last disagree");

    // zero fields on each beat kind
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last ? (edge_weight == '0 && parent_vertex == '0
                               && child_vertex == '0)
                            : (total_cost == '0)))
        else $error("unused result field not zero");

    // no command taken while a run still has tree edges to deliver
    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !in_ready)
        else $error("command accepted during emission");

    // command beats are never accepted back to back
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("back to back command accept");

endmodule

bind min_spanning_tree_dense_core mstd_checker u_mstd_checker (.*);

`default_nettype wire
